// ===== rtl/bavg_pkg.sv =====
// Shared types, constants and helpers for the block average downsampler.
package bavg_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_BLOCK  = 16;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int BS_W    = 5;
   localparam int WID_W   = 11;
   localparam int HGT_W   = 13;
   localparam int CSR_W   = 13;
   localparam int IDX_W   = 2;
   localparam int SUM_W   = 16;
   localparam int RUN_W   = 12;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int IB_W    = $clog2(MAX_BLOCK);
   localparam int SQ_W    = $clog2(MAX_BLOCK * MAX_BLOCK) + 1;
   localparam int STEP_W  = $clog2(SUM_W);

   localparam logic [IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [BS_W-1:0]  BS_RESET  = BS_W'(8);
   localparam logic [WID_W-1:0] WID_RESET = WID_W'(1024);
   localparam logic [HGT_W-1:0] HGT_RESET = HGT_W'(768);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   function automatic logic [BS_W-1:0] clamp_block(input logic [BS_W-1:0] v);
      logic [BS_W-1:0] r;
      r = v;
      if (v == '0) r = BS_W'(1);
      else if (v > BS_W'(MAX_BLOCK)) r = BS_W'(MAX_BLOCK);
      return r;
   endfunction

   function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
      logic [WID_W-1:0] r;
      r = v;
      if (v == '0) r = WID_W'(1);
      else if (v > WID_W'(MAX_WIDTH)) r = WID_W'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
      logic [HGT_W-1:0] r;
      r = v;
      if (v == '0) r = HGT_W'(1);
      else if (v > HGT_W'(MAX_HEIGHT)) r = HGT_W'(MAX_HEIGHT);
      return r;
   endfunction

endpackage

// ===== rtl/block_average_downsampler_unit.sv =====
// Block average downsampler: block sums per column, shared serial divider by N*N.
// A closing pixel passes the sum, divide and done steps; rsp_valid rises when the done
// step loads the result register. A new pixel is taken only in the idle state, after
// the last leaves the sum or done step; the 16-step restoring divider forms sum / (N*N)
// one bit a cycle; the done step holds while a stalled beat waits in the result register.
// Reset: synchronous, active high; registers return to 8 / 1024 / 768, counters to zero.
module block_average_downsampler_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bavg_pkg::PIX_W-1:0]    req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bavg_pkg::PIX_W-1:0]    rsp_avg_pixel,
   output logic                          rsp_row_end,
   output logic                          rsp_frame_end,
   input  logic                          csr_wr_en,
   input  logic [bavg_pkg::IDX_W-1:0]    csr_index,
   input  logic [bavg_pkg::CSR_W-1:0]    csr_wdata
);
   import bavg_pkg::*;

   state_type state_ff, state_in;

   logic [BS_W-1:0]   bs_ff, bs_in;
   logic [WID_W-1:0]  wid_ff, wid_in;
   logic [HGT_W-1:0]  hgt_ff, hgt_in;

   logic [PIX_W-1:0]  px_ff, px_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [COL_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [IB_W-1:0]   ibc_ff, ibc_in;
   logic [IB_W-1:0]   ibr_ff, ibr_in;
   logic [COL_W-1:0]  bcol_ff, bcol_in;
   logic [WID_W-1:0]  bstart_ff, bstart_in;
   logic [HGT_W-1:0]  rstart_ff, rstart_in;

   logic [SQ_W-1:0]   div_ff, div_in;
   logic [SQ_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              row_end_ff, row_end_in;
   logic              frame_end_ff, frame_end_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic              rsp_row_end_ff, rsp_row_end_in;
   logic              rsp_frame_end_ff, rsp_frame_end_in;

   logic [SUM_W-1:0]  sums_mem [MAX_WIDTH];
   logic [SUM_W-1:0]  rd_data_ff;

   logic              req_accept, rsp_accept;
   logic              mem_we, div_load, out_load, step_en;

   logic [BS_W-1:0]   n_eff;
   logic [WID_W-1:0]  w_eff;
   logic [HGT_W-1:0]  h_eff;
   logic [BS_W:0]     n_dbl;
   logic              col_ok, row_ok, in_region, seg_end, last_brow;
   logic              last_col, last_brow_of_frame, emit, row_wrap, frame_wrap;
   logic [RUN_W-1:0]  run_sum_add;
   logic [SUM_W-1:0]  total;
   logic [SQ_W:0]     rem_shift;
   logic              rem_ge;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   assign n_eff = clamp_block(bs_ff);
   assign w_eff = clamp_width(wid_ff);
   assign h_eff = clamp_height(hgt_ff);
   assign n_dbl = {n_eff, 1'b0};

   assign col_ok    = ({2'b00, bstart_ff} + (WID_W+2)'(n_eff)) <= {2'b00, w_eff};
   assign row_ok    = ({1'b0, rstart_ff} + (HGT_W+1)'(n_eff)) <= {1'b0, h_eff};
   assign in_region = col_ok && row_ok;
   assign seg_end   = (BS_W'(ibc_ff) + BS_W'(1)) >= n_eff;
   assign last_brow = (BS_W'(ibr_ff) + BS_W'(1)) >= n_eff;
   assign last_col  = ({2'b00, bstart_ff} + (WID_W+2)'(n_dbl)) > {2'b00, w_eff};
   assign last_brow_of_frame =
      ({1'b0, rstart_ff} + (HGT_W+1)'(n_dbl)) > {1'b0, h_eff};
   assign emit       = in_region && seg_end && last_brow;
   assign row_wrap   = ({1'b0, col_cnt_ff} + (COL_W+1)'(1)) >= (COL_W+1)'(w_eff);
   assign frame_wrap = ({1'b0, row_cnt_ff} + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);

   assign run_sum_add = run_ff + RUN_W'(px_ff);
   assign total = SUM_W'(run_sum_add) + ((ibr_ff != '0) ? rd_data_ff : '0);

   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = emit ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(SUM_W - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      div_load  = 1'b0;
      step_en   = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SUM: begin
            mem_we   = in_region && seg_end && !last_brow;
            div_load = emit;
         end
         ST_DIVIDE: begin
            step_en = 1'b1;
         end
         ST_DONE: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      bs_in  = bs_ff;
      wid_in = wid_ff;
      hgt_in = hgt_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_SIZE:   bs_in  = csr_wdata[BS_W-1:0];
            CSR_IMAGE_WIDTH:  wid_in = csr_wdata[WID_W-1:0];
            CSR_IMAGE_HEIGHT: hgt_in = csr_wdata[HGT_W-1:0];
            default:          bs_in  = bs_ff;
         endcase
      end
   end

   // raster counters and run sum
   always_comb begin
      px_in      = req_accept ? req_pixel : px_ff;
      run_in     = run_ff;
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      ibc_in     = ibc_ff;
      ibr_in     = ibr_ff;
      bcol_in    = bcol_ff;
      bstart_in  = bstart_ff;
      rstart_in  = rstart_ff;
      if (csr_wr_en && (csr_index == CSR_BLOCK_SIZE || csr_index == CSR_IMAGE_WIDTH ||
                        csr_index == CSR_IMAGE_HEIGHT)) begin
         run_in     = '0;
         col_cnt_in = '0;
         row_cnt_in = '0;
         ibc_in     = '0;
         ibr_in     = '0;
         bcol_in    = '0;
         bstart_in  = '0;
         rstart_in  = '0;
      end else if (state_ff == ST_SUM) begin
         if (in_region) begin
            if (seg_end) begin
               run_in    = '0;
               ibc_in    = '0;
               bcol_in   = bcol_ff + COL_W'(1);
               bstart_in = bstart_ff + WID_W'(n_eff);
            end else begin
               run_in = run_sum_add;
               ibc_in = ibc_ff + IB_W'(1);
            end
         end
         if (row_wrap) begin
            col_cnt_in = '0;
            bcol_in    = '0;
            ibc_in     = '0;
            run_in     = '0;
            bstart_in  = '0;
            if (frame_wrap) begin
               row_cnt_in = '0;
               ibr_in     = '0;
               rstart_in  = '0;
            end else begin
               row_cnt_in = row_cnt_ff + ROW_W'(1);
               if (last_brow) begin
                  ibr_in    = '0;
                  rstart_in = rstart_ff + HGT_W'(n_eff);
               end else begin
                  ibr_in = ibr_ff + IB_W'(1);
               end
            end
         end else begin
            col_cnt_in = col_cnt_ff + COL_W'(1);
         end
      end
   end

   // serial divider and result register
   always_comb begin
      div_in           = div_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      step_in          = step_ff;
      row_end_in       = row_end_ff;
      frame_end_in     = frame_end_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_avg_in       = rsp_avg_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (div_load) begin
         div_in       = SQ_W'(n_eff) * SQ_W'(n_eff);
         rem_in       = '0;
         quo_in       = total;
         step_in      = '0;
         row_end_in   = last_col;
         frame_end_in = last_col && last_brow_of_frame;
      end else if (step_en) begin
         rem_in  = rem_ge ? SQ_W'(rem_shift - {1'b0, div_ff}) : SQ_W'(rem_shift);
         quo_in  = {quo_ff[SUM_W-2:0], rem_ge};
         step_in = step_ff + STEP_W'(1);
      end
      if (rsp_accept) rsp_valid_in = 1'b0;
      if (out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_avg_in       = quo_ff[PIX_W-1:0];
         rsp_row_end_in   = row_end_ff;
         rsp_frame_end_in = frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bs_ff        <= BS_RESET;
         wid_ff       <= WID_RESET;
         hgt_ff       <= HGT_RESET;
         run_ff       <= '0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         ibc_ff       <= '0;
         ibr_ff       <= '0;
         bcol_ff      <= '0;
         bstart_ff    <= '0;
         rstart_ff    <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bs_ff        <= bs_in;
         wid_ff       <= wid_in;
         hgt_ff       <= hgt_in;
         run_ff       <= run_in;
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         ibc_ff       <= ibc_in;
         ibr_ff       <= ibr_in;
         bcol_ff      <= bcol_in;
         bstart_ff    <= bstart_in;
         rstart_ff    <= rstart_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff            <= px_in;
      div_ff           <= div_in;
      rem_ff           <= rem_in;
      quo_ff           <= quo_in;
      row_end_ff       <= row_end_in;
      frame_end_ff     <= frame_end_in;
      rsp_avg_ff       <= rsp_avg_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   // column sum store
   always_ff @(posedge clock) begin
      if (mem_we) sums_mem[bcol_ff] <= total;
      rd_data_ff <= sums_mem[bcol_ff];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_avg_pixel = rsp_avg_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_SUM)
      else $error("accepted beat did not enter the sum step");

   a_write_or_divide: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !div_load)
      else $error("column sum written on a block that closes");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> quo_ff[SUM_W-1:PIX_W] == '0)
      else $error("block mean exceeds pixel range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat raised outside the done step");

endmodule
